>>> rtl/core/gtp_pkg.sv
// ----------------------------------------------------------------------------
// GUID text parser package
// Shared constants, the queue entry type and the hex digit decoder.
// ----------------------------------------------------------------------------
package gtp_pkg;

	localparam int unsigned BaseLen    = 36;
	localparam int unsigned PosWidth   = 6;
	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] CharDash       = 8'h2D;
	localparam logic [7:0] CharBraceOpen  = 8'h7B;
	localparam logic [7:0] CharBraceClose = 8'h7D;
	localparam logic [7:0] CharZero       = 8'h30;
	localparam logic [7:0] CharNine       = 8'h39;
	localparam logic [7:0] CharLowerA     = 8'h61;
	localparam logic [7:0] CharLowerF     = 8'h66;
	localparam logic [7:0] CharUpperA     = 8'h41;
	localparam logic [7:0] CharUpperF     = 8'h46;

	localparam logic [PosWidth-1:0] PosMax = '1;

	localparam logic [PosWidth-1:0] DashSlot0 = 6'd8;
	localparam logic [PosWidth-1:0] DashSlot1 = 6'd13;
	localparam logic [PosWidth-1:0] DashSlot2 = 6'd18;
	localparam logic [PosWidth-1:0] DashSlot3 = 6'd23;

	typedef struct packed {
		logic       shift;
		logic [3:0] nibble;
		logic       bad;
		logic       last;
		logic       len_ok;
	} entry_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.valid = 1'b1;
		d.value = 4'd0;
		if (c >= CharZero && c <= CharNine) begin
			d.value = 4'(c - CharZero);
		end else if (c >= CharLowerA && c <= CharLowerF) begin
			d.value = 4'(c - CharLowerA + 8'd10);
		end else if (c >= CharUpperA && c <= CharUpperF) begin
			d.value = 4'(c - CharUpperA + 8'd10);
		end else begin
			d.valid = 1'b0;
		end
		return d;
	endfunction

endpackage

>>> rtl/core/gtp_in_if.sv
// ----------------------------------------------------------------------------
// GUID text parser character channel
// Carries one text character and its final-character flag per word.
// ----------------------------------------------------------------------------
interface gtp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

>>> rtl/core/gtp_out_if.sv
// ----------------------------------------------------------------------------
// GUID text parser result channel
// Carries the status and the four decoded GUID fields per word.
// ----------------------------------------------------------------------------
interface gtp_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] part1;
	logic [15:0] part2;
	logic [15:0] part3;
	logic [63:0] part4;

	modport source (output valid, output status, output part1, output part2,
		output part3, output part4, input ready);
	modport sink (input valid, input status, input part1, input part2,
		input part3, input part4, output ready);
endinterface

>>> rtl/core/gtp_cfg_if.sv
// ----------------------------------------------------------------------------
// GUID text parser configuration channel
// Carries the brace mode register value per word.
// ----------------------------------------------------------------------------
interface gtp_cfg_if;
	logic valid;
	logic ready;
	logic require_braces;

	modport source (output valid, output require_braces, input ready);
	modport sink (input valid, input require_braces, output ready);
endinterface

>>> rtl/core/guid_text_parser.sv
// ----------------------------------------------------------------------------
// GUID text parser
// Checks and decodes GUID text, one character per word, one result per text.
// ----------------------------------------------------------------------------
// The result word turns valid once the final character has passed through the
// queue and the result register, after any words still ahead of it in the queue.
// Throughput: one character per cycle while the queue is not full; the classifier,
// queue and accumulator each take one word per cycle, but the accumulator holds a
// final character while an earlier result waits on the sink. Reset clears the
// position count, brace mode, queue, accumulator, error flag and result valid; no clearing pass is needed.
module guid_text_parser #(
	parameter int unsigned QueueDepth = gtp_pkg::QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	gtp_in_if.sink    chars,
	gtp_cfg_if.sink   cfg,
	gtp_out_if.source guid
);

	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_not_empty;
	gtp_pkg::entry_t push_entry;
	gtp_pkg::entry_t pop_entry;

	gtp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.cfg        (cfg),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	gtp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (queue_full),
		.not_empty  (queue_not_empty),
		.pop_entry  (pop_entry)
	);

	gtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (queue_not_empty),
		.pop_entry (pop_entry),
		.pop       (pop),
		.guid      (guid)
	);

endmodule

>>> rtl/core/gtp_front.sv
// ----------------------------------------------------------------------------
// GUID text parser front end
// Tracks the character position and classifies each character.
// ----------------------------------------------------------------------------
module gtp_front (
	input  logic                clk,
	input  logic                arst_n,
	gtp_in_if.sink              chars,
	gtp_cfg_if.sink             cfg,
	input  logic                queue_full,
	output logic                push,
	output gtp_pkg::entry_t     push_entry
);

	logic                             braces_q;
	logic [gtp_pkg::PosWidth-1:0]     pos_q;
	logic [gtp_pkg::PosWidth-1:0]     len;
	logic [gtp_pkg::PosWidth-1:0]     rel_pos;
	logic [gtp_pkg::PosWidth:0]       pos_next_wide;
	logic                             dash_slot;
	gtp_pkg::hex_digit_t              digit;

	assign cfg.ready     = 1'b1;
	assign chars.ready   = !queue_full;
	assign push          = chars.valid && chars.ready;

	assign len           = gtp_pkg::PosWidth'(gtp_pkg::BaseLen) + {braces_q, 1'b0};
	assign rel_pos       = pos_q - gtp_pkg::PosWidth'(braces_q);
	assign pos_next_wide = {1'b0, pos_q} + 1'b1;
	assign dash_slot     = rel_pos == gtp_pkg::DashSlot0 || rel_pos == gtp_pkg::DashSlot1 ||
		rel_pos == gtp_pkg::DashSlot2 || rel_pos == gtp_pkg::DashSlot3;
	assign digit         = gtp_pkg::hex_decode(chars.char_code);

	always_comb begin
		push_entry.shift  = 1'b0;
		push_entry.nibble = digit.value;
		push_entry.bad    = 1'b0;
		push_entry.last   = chars.last_char;
		push_entry.len_ok = pos_next_wide == {1'b0, len};
		priority if (pos_q >= len) begin
			push_entry.bad = 1'b1;
		end else if (braces_q && pos_q == '0) begin
			push_entry.bad = chars.char_code != gtp_pkg::CharBraceOpen;
		end else if (braces_q && pos_q == len - 1'b1) begin
			push_entry.bad = chars.char_code != gtp_pkg::CharBraceClose;
		end else if (dash_slot) begin
			push_entry.bad = chars.char_code != gtp_pkg::CharDash;
		end else begin
			push_entry.bad   = !digit.valid;
			push_entry.shift = digit.valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			braces_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				braces_q <= cfg.require_braces;
			end
			if (push) begin
				if (chars.last_char) begin
					pos_q <= '0;
				end else if (pos_q != gtp_pkg::PosMax) begin
					pos_q <= pos_next_wide[gtp_pkg::PosWidth-1:0];
				end
			end
		end
	end

	// A final character always restarts the position count.
	assert property (@(posedge clk) disable iff (!arst_n)
		push && chars.last_char |=> pos_q == '0)
		else $error("position not cleared after final character");

	// A digit is only shifted in when the character carries no error.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(push_entry.shift && push_entry.bad))
		else $error("character both shifted and flagged bad");

endmodule

>>> rtl/core/gtp_queue.sv
// ----------------------------------------------------------------------------
// GUID text parser queue
// Small register queue that decouples classification from accumulation.
// ----------------------------------------------------------------------------
module gtp_queue #(
	parameter int unsigned Depth = gtp_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gtp_pkg::entry_t push_entry,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output gtp_pkg::entry_t pop_entry
);

	localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CountWidth = $clog2(Depth + 1);

	gtp_pkg::entry_t       store_q [Depth];
	logic [PtrWidth-1:0]   wr_ptr_q;
	logic [PtrWidth-1:0]   rd_ptr_q;
	logic [CountWidth-1:0] count_q;

	assign full      = count_q == CountWidth'(Depth);
	assign not_empty = count_q != '0;
	assign pop_entry = store_q[rd_ptr_q];

	function automatic logic [PtrWidth-1:0] ptr_inc(input logic [PtrWidth-1:0] p);
		return (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !not_empty))
		else $error("queue overflow or underflow");

endmodule

>>> rtl/core/gtp_back.sv
// ----------------------------------------------------------------------------
// GUID text parser back end
// Accumulates hex digits and registers one result per text.
// ----------------------------------------------------------------------------
module gtp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  gtp_pkg::entry_t pop_entry,
	output logic            pop,
	gtp_out_if.source       guid
);

	logic [127:0] acc_q;
	logic         bad_q;
	logic         out_valid_q;
	logic         status_q;
	logic [127:0] result_q;
	logic [127:0] acc_next;
	logic         bad_next;

	assign pop = not_empty && (!pop_entry.last || !out_valid_q || guid.ready);

	assign acc_next = pop_entry.shift ? {acc_q[123:0], pop_entry.nibble} : acc_q;
	assign bad_next = bad_q || pop_entry.bad;

	assign guid.valid  = out_valid_q;
	assign guid.status = status_q;
	assign guid.part1  = result_q[127:96];
	assign guid.part2  = result_q[95:80];
	assign guid.part3  = result_q[79:64];
	assign guid.part4  = result_q[63:0];

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			status_q <= bad_next || !pop_entry.len_ok;
			result_q <= (bad_next || !pop_entry.len_ok) ? '0 : acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (pop_entry.last) begin
					acc_q <= '0;
					bad_q <= 1'b0;
				end else begin
					acc_q <= acc_next;
					bad_q <= bad_next;
				end
			end
			if (pop && pop_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (guid.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An invalid text never shows decoded fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> result_q == '0)
		else $error("invalid result carries nonzero fields");

	// A pending result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !guid.ready |-> !(pop && pop_entry.last))
		else $error("result overwritten while stalled");

endmodule
